// ===== hdl/ufp_pkg.sv =====
// Shared types and constants for the ultrasonic frame parser.
// No dependencies; the files that use it refer to this package by scoped names.
`timescale 1ns / 1ps

package ufp_pkg;

    // Frame format
    localparam logic [7:0] HEADER_BYTE = 8'hFF;
    localparam logic [3:0] POS_HUNT    = 4'd0;
    localparam logic [3:0] POS_FIRST   = 4'd1;
    localparam logic [3:0] CHECK_POS   = 4'd9;
    localparam int         FRAME_DEPTH = 8;
    localparam int         NUM_DIST    = 4;

    // Item commands
    localparam logic CMD_BYTE = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    // Register widths, reset values and decode
    localparam int          MAX_DIST_WIDTH       = 16;
    localparam int          TIMEOUT_WIDTH        = 24;
    localparam int          TICK_COUNT_WIDTH_DEF = 24;
    localparam int          APB_ADDR_WIDTH       = 3;
    localparam int          APB_DATA_WIDTH       = 32;
    localparam logic [15:0] MAX_DIST_RESET       = 16'd1500;
    localparam logic [23:0] TIMEOUT_RESET        = 24'd300;
    localparam logic        REG_MAX_DIST         = 1'b0;
    localparam logic        REG_TIMEOUT          = 1'b1;

    // Configuration values handed from the register block to the parser
    typedef struct packed {
        logic [MAX_DIST_WIDTH-1:0] max_distance_mm;
        logic [TIMEOUT_WIDTH-1:0]  timeout_ticks;
    } cfg_t;

endpackage

// ===== hdl/ufp_if.sv =====
// Channel interfaces: input items (byte or tick) and distance reports.
// Depends on nothing; payload widths are fixed by the frame format.
`timescale 1ns / 1ps

interface ufp_item_if;
    logic       valid;
    logic       ready;
    logic       cmd;
    logic [7:0] rx_byte;

    modport source (output valid, output cmd, output rx_byte, input ready);
    modport sink   (input valid, input cmd, input rx_byte, output ready);
endinterface

interface ufp_report_if;
    logic        valid;
    logic        ready;
    logic [15:0] dist_a;
    logic [15:0] dist_b;
    logic [15:0] dist_c;
    logic [15:0] dist_d;
    logic        timed_out;

    modport source (output valid, output dist_a, output dist_b, output dist_c,
                    output dist_d, output timed_out, input ready);
    modport sink   (input valid, input dist_a, input dist_b, input dist_c,
                    input dist_d, input timed_out, output ready);
endinterface

// ===== hdl/ufp_apb_regs.sv =====
// APB configuration registers: distance limit and timeout in ticks.
// Depends on ufp_pkg.
`timescale 1ns / 1ps

module ufp_apb_regs (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [ufp_pkg::APB_ADDR_WIDTH-1:0]   paddr,
    input  logic [ufp_pkg::APB_DATA_WIDTH-1:0]   pwdata,
    output logic [ufp_pkg::APB_DATA_WIDTH-1:0]   prdata,
    output logic                                 pready,
    output ufp_pkg::cfg_t                        cfg
);

    logic [ufp_pkg::MAX_DIST_WIDTH-1:0] max_dist_reg;
    logic [ufp_pkg::TIMEOUT_WIDTH-1:0]  timeout_reg;
    logic                               wr_en;
    logic                               reg_idx;

    // Registers sit at byte addresses 0 and 4; the word index is the top address bit.
    assign reg_idx = paddr[ufp_pkg::APB_ADDR_WIDTH-1];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;

    // Register write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_dist_reg <= ufp_pkg::MAX_DIST_RESET;
            timeout_reg  <= ufp_pkg::TIMEOUT_RESET;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                ufp_pkg::REG_MAX_DIST:
                    max_dist_reg <= pwdata[ufp_pkg::MAX_DIST_WIDTH-1:0];
                ufp_pkg::REG_TIMEOUT:
                    timeout_reg <= pwdata[ufp_pkg::TIMEOUT_WIDTH-1:0];
                default:
                    max_dist_reg <= max_dist_reg;
            endcase
        end
    end

    // Read back, zero-extended to the bus width
    always_comb
    begin
        case (reg_idx)
            ufp_pkg::REG_MAX_DIST:
                prdata = ufp_pkg::APB_DATA_WIDTH'(max_dist_reg);
            ufp_pkg::REG_TIMEOUT:
                prdata = ufp_pkg::APB_DATA_WIDTH'(timeout_reg);
            default:
                prdata = '0;
        endcase
    end

    assign cfg.max_distance_mm = max_dist_reg;
    assign cfg.timeout_ticks   = timeout_reg;

endmodule

// ===== hdl/ufp_parser.sv =====
// Frame hunter, checksum check, idle tick counter and the report register.
// Depends on ufp_pkg and the channel interfaces in ufp_if.sv.
`timescale 1ns / 1ps

module ufp_parser #(
    parameter int TICK_COUNT_WIDTH = ufp_pkg::TICK_COUNT_WIDTH_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  ufp_pkg::cfg_t        cfg,
    ufp_item_if.sink             item,
    ufp_report_if.source         report
);

    localparam int CmpWidth = (TICK_COUNT_WIDTH > ufp_pkg::TIMEOUT_WIDTH) ?
                              TICK_COUNT_WIDTH : ufp_pkg::TIMEOUT_WIDTH;
    localparam logic [TICK_COUNT_WIDTH-1:0] TickMax = '1;
    localparam int FrameIdxWidth = $clog2(ufp_pkg::FRAME_DEPTH);

    // Control and stored state
    logic [3:0]                  pos_reg,   pos_next;
    logic [7:0]                  sum_reg,   sum_next;
    logic [TICK_COUNT_WIDTH-1:0] idle_reg,  idle_next;
    logic [7:0]                  frame_reg  [ufp_pkg::FRAME_DEPTH];
    logic [7:0]                  frame_next [ufp_pkg::FRAME_DEPTH];
    logic [15:0]                 last_reg   [ufp_pkg::NUM_DIST];
    logic [15:0]                 last_next  [ufp_pkg::NUM_DIST];

    // Report register
    logic                        out_valid_reg, out_valid_next;
    logic [15:0]                 out_dist_reg  [ufp_pkg::NUM_DIST];
    logic [15:0]                 out_dist_next [ufp_pkg::NUM_DIST];
    logic                        out_timed_reg, out_timed_next;

    logic                        accept;
    logic [TICK_COUNT_WIDTH-1:0] idle_inc;
    logic                        timeout_hit;
    logic                        sum_ok;
    logic [15:0]                 fresh_dist [ufp_pkg::NUM_DIST];

    // A new beat is taken whenever the report register is empty or being drained.
    assign item.ready = !out_valid_reg || report.ready;
    assign accept     = item.valid && item.ready;

    // Saturating tick count and timeout compare
    assign idle_inc    = (idle_reg == TickMax) ? idle_reg
                                               : idle_reg + TICK_COUNT_WIDTH'(1);
    assign timeout_hit = CmpWidth'(idle_inc) >= CmpWidth'(cfg.timeout_ticks);
    assign sum_ok      = (pos_reg == ufp_pkg::CHECK_POS) && (item.rx_byte == sum_reg);

    // Big-endian distances from the frame store; any above the limit read as zero
    always_comb
    begin
        logic [15:0] raw;
        for (int i = 0; i < ufp_pkg::NUM_DIST; i++)
        begin
            raw = {frame_reg[2*i], frame_reg[2*i+1]};
            fresh_dist[i] = (raw > cfg.max_distance_mm) ? 16'd0 : raw;
        end
    end

    // Next-state logic for one accepted beat
    always_comb
    begin
        pos_next       = pos_reg;
        sum_next       = sum_reg;
        idle_next      = idle_reg;
        frame_next     = frame_reg;
        last_next      = last_reg;
        out_valid_next = out_valid_reg && !report.ready;
        out_dist_next  = out_dist_reg;
        out_timed_next = out_timed_reg;

        if (accept)
        begin
            case (item.cmd)
                ufp_pkg::CMD_TICK:
                begin
                    idle_next = idle_inc;
                    if (timeout_hit)
                    begin
                        out_valid_next = 1'b1;
                        out_dist_next  = last_reg;
                        out_timed_next = 1'b1;
                    end
                end
                ufp_pkg::CMD_BYTE:
                begin
                    if (pos_reg == ufp_pkg::POS_HUNT)
                    begin
                        if (item.rx_byte == ufp_pkg::HEADER_BYTE)
                        begin
                            sum_next = item.rx_byte;
                            pos_next = ufp_pkg::POS_FIRST;
                        end
                    end
                    else if (pos_reg < ufp_pkg::CHECK_POS)
                    begin
                        frame_next[FrameIdxWidth'(pos_reg - ufp_pkg::POS_FIRST)] =
                            item.rx_byte;
                        sum_next = sum_reg + item.rx_byte;
                        pos_next = pos_reg + 4'd1;
                    end
                    else
                    begin
                        // Checksum byte ends the frame either way.
                        pos_next = ufp_pkg::POS_HUNT;
                        sum_next = 8'd0;
                        if (sum_ok)
                        begin
                            last_next      = fresh_dist;
                            idle_next      = '0;
                            out_valid_next = 1'b1;
                            out_dist_next  = fresh_dist;
                            out_timed_next = 1'b0;
                        end
                    end
                end
                default:
                begin
                    pos_next = pos_reg;
                end
            endcase
        end
    end

    // Control state and stored distances
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= ufp_pkg::POS_HUNT;
            sum_reg       <= 8'd0;
            idle_reg      <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < ufp_pkg::NUM_DIST; i++)
            begin
                last_reg[i] <= 16'd0;
            end
        end
        else
        begin
            pos_reg       <= pos_next;
            sum_reg       <= sum_next;
            idle_reg      <= idle_next;
            out_valid_reg <= out_valid_next;
            last_reg      <= last_next;
        end
    end

    // Payload storage: frame bytes and report fields
    always_ff @(posedge clk)
    begin
        frame_reg     <= frame_next;
        out_dist_reg  <= out_dist_next;
        out_timed_reg <= out_timed_next;
    end

    assign report.valid     = out_valid_reg;
    assign report.dist_a    = out_dist_reg[0];
    assign report.dist_b    = out_dist_reg[1];
    assign report.dist_c    = out_dist_reg[2];
    assign report.dist_d    = out_dist_reg[3];
    assign report.timed_out = out_timed_reg;

    // The frame position never runs past the checksum byte.
    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= ufp_pkg::CHECK_POS)
        else $error("frame position out of range");

    // Input stalls only while a report waits on a stalled output.
    a_ready_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !item.ready |-> (out_valid_reg && !report.ready))
        else $error("input stalled without a pending report");

    // A matching checksum yields a fresh report and clears the tick count.
    a_good_frame: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && item.cmd == ufp_pkg::CMD_BYTE && sum_ok)
        |=> (report.valid && !report.timed_out && idle_reg == '0))
        else $error("good frame not reported");

    // A header while hunting opens a frame with the header in the sum.
    a_header: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && item.cmd == ufp_pkg::CMD_BYTE && pos_reg == ufp_pkg::POS_HUNT &&
         item.rx_byte == ufp_pkg::HEADER_BYTE)
        |=> (pos_reg == ufp_pkg::POS_FIRST && sum_reg == ufp_pkg::HEADER_BYTE))
        else $error("header did not open a frame");

    // Ticks count up by one until the counter is full.
    a_tick_count: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && item.cmd == ufp_pkg::CMD_TICK && idle_reg != TickMax)
        |=> (idle_reg == $past(idle_reg) + TICK_COUNT_WIDTH'(1)))
        else $error("tick count did not advance");

endmodule

// ===== hdl/ultrasonic_frame_parser_unit.sv =====
// Top level of the ultrasonic frame parser: APB registers plus the parser core.
// Depends on ufp_pkg, ufp_if.sv, ufp_apb_regs and ufp_parser.
`timescale 1ns / 1ps

// Channel   Role    Beat contents
// -------   -----   ---------------------------------------------------
// item      sink    cmd (byte or tick), rx_byte
// report    source  dist_a, dist_b, dist_c, dist_d, timed_out
// apb       slave   max_distance_mm at 0x0, timeout_ticks at 0x4
//
// One item is taken per cycle while item.ready is high; a report appears in the cycle after the beat
// that causes it, held in a single output register.
// An item is refused only while that register holds a report and report.ready is low.
// rst_n clears the frame position, checksum, tick count and stored distances;
// the limits return to 1500 mm and 300 ticks. No clearing pass is needed.

module ultrasonic_frame_parser_unit #(
    parameter int TICK_COUNT_WIDTH = ufp_pkg::TICK_COUNT_WIDTH_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [ufp_pkg::APB_ADDR_WIDTH-1:0] paddr,
    input  logic [ufp_pkg::APB_DATA_WIDTH-1:0] pwdata,
    output logic [ufp_pkg::APB_DATA_WIDTH-1:0] prdata,
    output logic                               pready,
    ufp_item_if.sink                           item,
    ufp_report_if.source                       report
);

    ufp_pkg::cfg_t cfg;

    // Configuration registers
    ufp_apb_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Frame parsing and reporting
    ufp_parser #(
        .TICK_COUNT_WIDTH (TICK_COUNT_WIDTH)
    ) u_parser (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .item   (item),
        .report (report)
    );

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for ultrasonic_frame_parser_unit: byte and tick beats in,
// distance reports out, limits set over APB. Depends on ufp_pkg, ufp_if.sv and the RTL.
`timescale 1ns / 1ps

module testbench;

    // The tick counter is built narrow so that saturation is reachable in a short run.
    localparam int TICK_W      = 8;
    localparam int CYCLE_LIMIT = 400000;
    localparam int LONG_HOLD   = 300;
    localparam int HOLD_STRIDE = 410;

    localparam logic [ufp_pkg::APB_ADDR_WIDTH-1:0] ADDR_MAX_DIST = {ufp_pkg::REG_MAX_DIST, 2'b00};
    localparam logic [ufp_pkg::APB_ADDR_WIDTH-1:0] ADDR_TIMEOUT  = {ufp_pkg::REG_TIMEOUT, 2'b00};
    localparam logic [TICK_W-1:0] TICK_FULL = '1;

    typedef struct packed {
        logic       cmd;
        logic [7:0] rx_byte;
    } parser_item_t;

    typedef struct packed {
        logic [15:0] dist_a;
        logic [15:0] dist_b;
        logic [15:0] dist_c;
        logic [15:0] dist_d;
        logic        timed_out;
    } distance_report_t;

    logic                               clk;
    logic                               rst_n;
    logic                               psel;
    logic                               penable;
    logic                               pwrite;
    logic [ufp_pkg::APB_ADDR_WIDTH-1:0] paddr;
    logic [ufp_pkg::APB_DATA_WIDTH-1:0] pwdata;
    logic [ufp_pkg::APB_DATA_WIDTH-1:0] prdata;
    logic                               pready;

    ufp_item_if   item_ch ();
    ufp_report_if report_ch ();

    ultrasonic_frame_parser_unit #(
        .TICK_COUNT_WIDTH (TICK_W)
    ) uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .item    (item_ch),
        .report  (report_ch)
    );

    // Beats waiting to be driven and reports the parser is expected to send.
    parser_item_t     pending_items[$];
    distance_report_t expected_reports[$];

    // Predicted parser state and its copy of the limits.
    logic [15:0]       lim_mm;
    logic [23:0]       lim_ticks;
    logic [3:0]        frame_pos;
    logic [7:0]        frame_sum;
    logic [7:0]        frame_store [0:7];
    logic [15:0]       held_dist [0:3];
    logic [TICK_W-1:0] ticks_since_frame;

    int  error_count;
    int  stim_count;
    int  items_accepted;
    int  reports_seen;
    bit  beat_taken;
    int  tx_gap;
    bit  steady_tx;
    int  rx_stall;
    int  hold_left;
    int  next_hold_mark;
    bit  steady_rx;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    task automatic note_mismatch(input string msg);
        $display("MISMATCH at %0t: %s", $realtime, msg);
        error_count++;
    endtask

    task automatic check_field(input string name, input logic [15:0] got,
                               input logic [15:0] want);
        if (got !== want)
            note_mismatch($sformatf("report %0d %s: got %0h, expected %0h",
                                    reports_seen, name, got, want));
    endtask

    // Advance the predicted parser by one accepted beat.
    task automatic parse_beat(input logic cmd, input logic [7:0] b);
        distance_report_t rep;
        logic [15:0]      d;
        bit               good;
        if (cmd == ufp_pkg::CMD_TICK)
        begin
            if (ticks_since_frame != TICK_FULL)
                ticks_since_frame++;
            if (ticks_since_frame >= lim_ticks)
            begin
                rep = {held_dist[0], held_dist[1], held_dist[2], held_dist[3], 1'b1};
                expected_reports.push_back(rep);
            end
        end
        else if (frame_pos == ufp_pkg::POS_HUNT)
        begin
            if (b == ufp_pkg::HEADER_BYTE)
            begin
                frame_sum = b;
                frame_pos = ufp_pkg::POS_FIRST;
            end
        end
        else if (frame_pos < ufp_pkg::CHECK_POS)
        begin
            frame_store[frame_pos[2:0] - 3'd1] = b;
            frame_sum = frame_sum + b;
            frame_pos = frame_pos + 4'd1;
        end
        else
        begin
            // Checksum byte closes the frame whether it matches or not.
            good = (frame_pos == ufp_pkg::CHECK_POS) && (b == frame_sum);
            frame_pos = ufp_pkg::POS_HUNT;
            frame_sum = 8'd0;
            if (good)
            begin
                for (int k = 0; k < ufp_pkg::NUM_DIST; k++)
                begin
                    d = {frame_store[2*k], frame_store[2*k+1]};
                    held_dist[k] = (d > lim_mm) ? 16'd0 : d;
                end
                ticks_since_frame = '0;
                rep = {held_dist[0], held_dist[1], held_dist[2], held_dist[3], 1'b0};
                expected_reports.push_back(rep);
            end
        end
    endtask

    function automatic int pick_gap(input bit steady);
        int r;
        if (steady)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 70)
            return 0;
        else if (r < 94)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    // Accepted beats feed the predictor; accepted reports are checked in order.
    always @(posedge clk)
    begin
        distance_report_t want;
        beat_taken = 1'b0;
        if (rst_n)
        begin
            if (item_ch.valid && item_ch.ready)
            begin
                parse_beat(item_ch.cmd, item_ch.rx_byte);
                void'(pending_items.pop_front());
                items_accepted++;
                beat_taken = 1'b1;
            end
            if (report_ch.valid === 1'b1 && report_ch.ready)
            begin
                reports_seen++;
                if (expected_reports.size() == 0)
                    note_mismatch($sformatf("report %0d arrived with none expected",
                                            reports_seen));
                else
                begin
                    want = expected_reports.pop_front();
                    check_field("dist_a", report_ch.dist_a, want.dist_a);
                    check_field("dist_b", report_ch.dist_b, want.dist_b);
                    check_field("dist_c", report_ch.dist_c, want.dist_c);
                    check_field("dist_d", report_ch.dist_d, want.dist_d);
                    check_field("timed_out", 16'(report_ch.timed_out),
                                16'(want.timed_out));
                end
            end
        end
    end

    // Item driver: holds a beat until taken, then idles for a random gap.
    always @(negedge clk)
    begin
        if ($urandom_range(0, 199) == 0)
            steady_tx = !steady_tx;
        if (rst_n && (!item_ch.valid || beat_taken))
        begin
            if (beat_taken)
                tx_gap = pick_gap(steady_tx);
            if (tx_gap > 0)
            begin
                tx_gap--;
                item_ch.valid <= 1'b0;
            end
            else if (pending_items.size() != 0)
            begin
                item_ch.valid   <= 1'b1;
                item_ch.cmd     <= pending_items[0].cmd;
                item_ch.rx_byte <= pending_items[0].rx_byte;
            end
            else
                item_ch.valid <= 1'b0;
        end
    end

    // Report receiver: random stalls, plus a long hold every so often so the
    // output register fills and the item side backs up.
    always @(negedge clk)
    begin
        if ($urandom_range(0, 199) == 0)
            steady_rx = !steady_rx;
        if (rst_n)
        begin
            if (hold_left == 0 && items_accepted >= next_hold_mark)
            begin
                hold_left = LONG_HOLD;
                next_hold_mark = next_hold_mark + HOLD_STRIDE;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                report_ch.ready <= 1'b0;
            end
            else
            begin
                if (rx_stall == 0)
                    rx_stall = pick_gap(steady_rx);
                if (rx_stall > 0)
                begin
                    rx_stall--;
                    report_ch.ready <= 1'b0;
                end
                else
                    report_ch.ready <= 1'b1;
            end
        end
    end

    // Watchdog.
    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("*** FAILED ***");
        $finish;
    end

    task automatic add_item(input logic cmd, input logic [7:0] b);
        pending_items.push_back('{cmd: cmd, rx_byte: b});
        stim_count++;
    endtask

    task automatic add_tick();
        add_item(ufp_pkg::CMD_TICK, 8'($urandom));
    endtask

    // One frame: header, four big-endian distances, checksum. A tick may be
    // slipped in ahead of frame byte tick_slot.
    task automatic add_frame(input logic [63:0] dists, input bit bad_sum, input int tick_slot);
        logic [7:0] sum;
        logic [7:0] b;
        sum = ufp_pkg::HEADER_BYTE;
        if (tick_slot == 0)
            add_tick();
        add_item(ufp_pkg::CMD_BYTE, ufp_pkg::HEADER_BYTE);
        for (int k = 0; k < 8; k++)
        begin
            b = dists[63 - 8*k -: 8];
            sum = sum + b;
            if (tick_slot == k + 1)
                add_tick();
            add_item(ufp_pkg::CMD_BYTE, b);
        end
        if (bad_sum)
            sum = sum + 8'($urandom_range(1, 255));
        if (tick_slot == 9)
            add_tick();
        add_item(ufp_pkg::CMD_BYTE, sum);
    endtask

    function automatic logic [15:0] pick_distance();
        int base;
        int v;
        case ($urandom_range(0, 3))
            0: return 16'($urandom);
            1:
            begin
                base = int'(lim_mm);
                v = base + int'($urandom_range(0, 4)) - 2;
                if (v < 0)
                    v = 0;
                if (v > 65535)
                    v = 65535;
                return 16'(v);
            end
            2: return 16'($urandom_range(0, lim_mm));
            default: return 16'($urandom) | 16'hFF00;
        endcase
    endfunction

    function automatic logic [63:0] random_dists();
        return {pick_distance(), pick_distance(), pick_distance(), pick_distance()};
    endfunction

    // Mostly well-formed frames with random content, mixed with ticks and noise.
    task automatic run_random(input int n);
        int first;
        int r;
        int slot;
        int cnt;
        first = stim_count;
        @(posedge clk);
        while (stim_count - first < n)
        begin
            r = $urandom_range(0, 99);
            if (r < 55)
            begin
                slot = ($urandom_range(0, 4) == 0) ? int'($urandom_range(0, 9)) : -1;
                add_frame(random_dists(), 1'b0, slot);
            end
            else if (r < 65)
                add_frame(random_dists(), 1'b1, -1);
            else if (r < 85)
            begin
                cnt = $urandom_range(1, 6);
                repeat (cnt) add_tick();
            end
            else if (r < 94)
            begin
                cnt = $urandom_range(1, 3);
                repeat (cnt) add_item(ufp_pkg::CMD_BYTE, 8'($urandom_range(0, 254)));
            end
            else
            begin
                // Truncated frame: its tail swallows the next header as data.
                add_item(ufp_pkg::CMD_BYTE, ufp_pkg::HEADER_BYTE);
                cnt = $urandom_range(1, 7);
                repeat (cnt) add_item(ufp_pkg::CMD_BYTE, 8'($urandom));
            end
        end
    endtask

    task automatic wait_drained();
        do
            @(negedge clk);
        while (pending_items.size() != 0 || expected_reports.size() != 0);
        repeat (4) @(negedge clk);
    endtask

    // APB write followed by a read back of the same register.
    task automatic write_reg(input logic [ufp_pkg::APB_ADDR_WIDTH-1:0] addr,
                             input logic [31:0] value);
        logic [31:0] got;
        logic [31:0] want;
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == ADDR_MAX_DIST)
        begin
            lim_mm = value[15:0];
            want = {16'd0, lim_mm};
        end
        else
        begin
            lim_ticks = value[23:0];
            want = {8'd0, lim_ticks};
        end
        @(negedge clk);
        psel <= 1'b1;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        got = prdata;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (got !== want)
            note_mismatch($sformatf("register at %0h read %0h, expected %0h", addr, got, want));
    endtask

    // Limits change only once every report is in; upper bus bits are junk.
    task automatic set_limits(input logic [15:0] mm, input logic [23:0] ticks);
        wait_drained();
        write_reg(ADDR_MAX_DIST, {16'($urandom), mm});
        write_reg(ADDR_TIMEOUT, {8'($urandom), ticks});
    endtask

    initial
    begin
        rst_n           = 1'b0;
        psel            = 1'b0;
        penable         = 1'b0;
        pwrite          = 1'b0;
        paddr           = '0;
        pwdata          = '0;
        item_ch.valid   = 1'b0;
        item_ch.cmd     = ufp_pkg::CMD_BYTE;
        item_ch.rx_byte = 8'd0;
        report_ch.ready = 1'b0;

        lim_mm            = ufp_pkg::MAX_DIST_RESET;
        lim_ticks         = ufp_pkg::TIMEOUT_RESET;
        frame_pos         = ufp_pkg::POS_HUNT;
        frame_sum         = 8'd0;
        ticks_since_frame = '0;
        for (int k = 0; k < ufp_pkg::NUM_DIST; k++)
            held_dist[k] = 16'd0;
        error_count    = 0;
        stim_count     = 0;
        items_accepted = 0;
        reports_seen   = 0;
        beat_taken     = 1'b0;
        tx_gap         = 0;
        steady_tx      = 1'b0;
        rx_stall       = 0;
        hold_left      = 0;
        next_hold_mark = 150;
        steady_rx      = 1'b0;

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Reset limits. Noise while hunting, a good frame whose data holds
        // header bytes and hits both sides of the limit, then a frame with a
        // tick in the middle and a wrong checksum.
        @(posedge clk);
        add_item(ufp_pkg::CMD_BYTE, 8'h00);
        add_frame({16'hFFFF, 16'h0000, 16'd1500, 16'd1501}, 1'b0, -1);
        add_frame({16'd1, 16'h00FF, 16'd1499, 16'h8000}, 1'b1, 4);
        run_random(180);

        // Widest limit and the shortest timeout: every tick reports.
        set_limits(16'hFFFF, 24'd1);
        run_random(160);

        // Zero limit and the longest timeout.
        set_limits(16'h0000, 24'hFFFFFF);
        run_random(120);

        // Zero timeout reports on every tick.
        set_limits(16'($urandom_range(200, 5000)), 24'd0);
        run_random(120);

        // Timeout at the counter's ceiling: a long run of ticks saturates it.
        set_limits(16'($urandom_range(200, 5000)), 24'(TICK_FULL));
        @(posedge clk);
        repeat (300) add_tick();
        run_random(60);

        // A couple of short random timeouts.
        repeat (2)
        begin
            set_limits(16'($urandom_range(200, 5000)), 24'($urandom_range(2, 40)));
            run_random(100);
        end

        wait_drained();
        repeat (10) @(negedge clk);
        if (error_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// ===== ultrasonic_frame_parser_unit.f =====
hdl/ufp_pkg.sv
hdl/ufp_if.sv
hdl/ufp_apb_regs.sv
hdl/ufp_parser.sv
hdl/ultrasonic_frame_parser_unit.sv
tb/testbench.sv
